FILE: design/keyboard_scancode_to_ascii_macros.svh
// Assertion macros for the checker file.
`ifndef KEYBOARD_SCANCODE_TO_ASCII_MACROS_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_MACROS_SVH

// Property checked on every clock edge outside reset.
`define KBDSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define KBDSC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/kbdsc_pkg.sv
package kbdsc_pkg;

  typedef logic [7:0] code_t;
  typedef logic [7:0] char_t;
  typedef logic [2:0] leds_t;
  typedef logic [1:0] shift_t;

  // Scan codes with a special meaning.
  localparam code_t CodeCapsLock   = 8'h3a;
  localparam code_t CodeNumLock    = 8'h45;
  localparam code_t CodeScrollLock = 8'h46;
  localparam code_t CodeLShiftMake = 8'h2a;
  localparam code_t CodeRShiftMake = 8'h36;
  localparam code_t CodeLShiftBrk  = 8'haa;
  localparam code_t CodeRShiftBrk  = 8'hb6;
  localparam code_t CodeBackspace  = 8'h0e;
  localparam code_t CodeEnter      = 8'h1c;

  localparam int    RomDepth = 84;
  localparam code_t RomLimit = 8'h54;

  localparam char_t ChNone      = 8'h00;
  localparam char_t ChBackspace = 8'h08;
  localparam char_t ChEnter     = 8'h0a;
  localparam char_t ChUpperA    = 8'h41;
  localparam char_t ChUpperZ    = 8'h5a;
  localparam char_t CaseOffset  = 8'h20;

  // Shift states.
  localparam shift_t ShiftNone = 2'b00;
  localparam shift_t ShiftBoth = 2'b11;

  localparam char_t RomPlain [RomDepth] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e
  };

  localparam char_t RomShifted [RomDepth] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e
  };

  // Decoder result for one scan code, with the state it leaves behind.
  typedef struct packed {
    char_t  key_code;
    logic   led_changed;
    leds_t  leds;
    shift_t shift;
  } dec_res_t;

endpackage

FILE: design/kbdsc_code_if.sv
interface kbdsc_code_if import kbdsc_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink (input valid, input scan_code, output ready);
endinterface

FILE: design/kbdsc_key_if.sv
interface kbdsc_key_if import kbdsc_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t key_code;
  logic  key_valid;
  logic  led_changed;
  leds_t led_state;

  modport source (output valid, output key_code, output key_valid,
                  output led_changed, output led_state, input ready);
  modport sink (input valid, input key_code, input key_valid,
                input led_changed, input led_state, output ready);
endinterface

FILE: design/kbdsc_decode.sv
module kbdsc_decode import kbdsc_pkg::*; (
  input  code_t    code,
  input  shift_t   shift,
  input  leds_t    leds,
  output dec_res_t res
);

  leds_t lock_hit;
  leds_t leds_next;
  char_t rom_char;
  char_t ch;
  logic  caps;
  logic  shifted;

  assign lock_hit  = {code == CodeCapsLock, code == CodeNumLock, code == CodeScrollLock};
  assign leds_next = leds ^ lock_hit;
  assign caps      = leds_next[2];
  assign shifted   = (shift != ShiftNone);

  always_comb begin
    rom_char = ChNone;
    if (code < RomLimit) begin
      if (shift == ShiftNone) begin
        rom_char = RomPlain[code[6:0]];
      end else if (shift != ShiftBoth) begin
        rom_char = RomShifted[code[6:0]];
      end
    end
  end

  always_comb begin
    ch = rom_char;
    // Lower the letter unless exactly one of caps lock and shift applies.
    if (rom_char >= ChUpperA && rom_char <= ChUpperZ && caps == shifted) begin
      ch = rom_char + CaseOffset;
    end
    if (code == CodeBackspace) begin
      ch = ChBackspace;
    end
    if (code == CodeEnter) begin
      ch = ChEnter;
    end
  end

  always_comb begin
    res.key_code    = ch;
    res.led_changed = |lock_hit;
    res.leds        = leds_next;
    res.shift       = shift;
    if (code == CodeLShiftMake) res.shift[0] = 1'b1;
    if (code == CodeRShiftMake) res.shift[1] = 1'b1;
    if (code == CodeLShiftBrk)  res.shift[0] = 1'b0;
    if (code == CodeRShiftBrk)  res.shift[1] = 1'b0;
  end

endmodule

FILE: design/keyboard_scancode_to_ascii.sv
// Channel | Direction | Payload
// --------+-----------+-----------------------------------------------
// scan    | in        | scan_code[7:0]
// key     | out       | key_code[7:0], key_valid, led_changed, led_state[2:0]
// cfg     | in        | cfg_we, cfg_data[2:0] (loads the lock LED state)
//
// One item per cycle sustained while key is not stalled; an accepted scan code
// passes the input register, then the result register, before it shows on key.
// Reset clears shift state, lock LEDs and both valid flags.
// A stall on key holds the result; the input register still drains into it
// as soon as it frees, so scan stays ready whenever the pipe has a free slot.
module keyboard_scancode_to_ascii import kbdsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  kbdsc_code_if.sink  scan,
  kbdsc_key_if.source key,
  input  logic        cfg_we,
  input  leds_t       cfg_data
);

  // Input register.
  logic     s1_valid;
  code_t    s1_code;

  // Keyboard state carried from item to item.
  shift_t   shift;
  leds_t    leds;

  dec_res_t dec;
  logic     advance;

  // Result register moves when empty or being taken downstream.
  assign advance    = !key.valid || key.ready;
  assign scan.ready = !s1_valid || advance;

  kbdsc_decode u_decode (
    .code  (s1_code),
    .shift (shift),
    .leds  (leds),
    .res   (dec)
  );

  // Control and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      key.valid <= 1'b0;
      shift     <= ShiftNone;
      leds      <= '0;
    end else begin
      if (scan.ready) begin
        s1_valid <= scan.valid;
      end
      if (advance) begin
        key.valid <= s1_valid;
        // Commit the state change of the item leaving the input register.
        if (s1_valid) begin
          shift <= dec.shift;
          leds  <= dec.leds;
        end
      end
      // Writes must arrive only while idle; the block does not enforce it. Load the LED state directly.
      if (cfg_we) begin
        leds <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (scan.ready) begin
      s1_code <= scan.scan_code;
    end
    if (advance && s1_valid) begin
      key.key_code    <= dec.key_code;
      key.key_valid   <= (dec.key_code != ChNone);
      key.led_changed <= dec.led_changed;
      key.led_state   <= dec.leds;
    end
  end

endmodule

FILE: design/kbdsc_checker.sv
`include "keyboard_scancode_to_ascii_macros.svh"

module kbdsc_checker import kbdsc_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  out_valid,
  input logic  out_ready,
  input char_t key_code,
  input logic  key_valid,
  input logic  led_changed,
  input leds_t led_state
);

  `KBDSC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid right after reset")

  `KBDSC_ASSERT(a_flag_matches, clk, rst, out_valid |-> (key_valid == (key_code != ChNone)), "key_valid disagrees with key_code")

  `KBDSC_ASSERT(a_lock_no_char, clk, rst, (out_valid && led_changed) |-> !key_valid, "lock key produced a character")

  `KBDSC_ASSERT(a_hold_stall, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(key_code) && $stable(led_state)), "stalled result changed")

endmodule

bind keyboard_scancode_to_ascii kbdsc_checker u_kbdsc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (key.valid),
  .out_ready   (key.ready),
  .key_code    (key.key_code),
  .key_valid   (key.key_valid),
  .led_changed (key.led_changed),
  .led_state   (key.led_state)
);

FILE: bench/testbench.sv
`default_nettype none

// Top of the scan code decoder bench. Prediction runs on every accepted scan item.
module testbench import kbdsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of the key maps: unshifted and shifted characters per scan code.
  localparam char_t PlainKeys [RomDepth] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e
  };

  localparam char_t ShiftedKeys [RomDepth] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e
  };

  // LED bit masks and a few scan codes the stimulus names.
  localparam leds_t LedCaps   = 3'b100;
  localparam leds_t LedNum    = 3'b010;
  localparam leds_t LedScroll = 3'b001;
  localparam leds_t LedsOff   = 3'b000;
  localparam leds_t LedsAll   = 3'b111;
  localparam code_t BreakBit  = 8'h80;
  localparam code_t KeyA      = 8'h1e;
  localparam code_t KeyOne    = 8'h02;
  localparam code_t KeySpace  = 8'h39;
  localparam code_t KeyPadDot = 8'h53;
  localparam code_t ByteAck   = 8'hfa;
  localparam code_t ByteResend = 8'hfe;
  localparam code_t ByteMax   = 8'hff;
  localparam code_t ByteZero  = 8'h00;

  localparam int LongStall  = 64;
  localparam int QuietLimit = 2000;
  localparam int PhaseCount = 4;
  localparam int PhaseItems = 175;

  // Walk the corner cases: both ends of the byte, caps and shift mixes, both
  // shifts held, control keys, every lock key, lock break, controller bytes,
  // last table entry and the first code past it.
  localparam code_t DirectedCodes [25] = '{
    ByteZero, ByteMax, KeyA, CodeCapsLock, KeyA, CodeLShiftMake, KeyA, KeyOne,
    CodeRShiftMake, KeyA, CodeBackspace, CodeLShiftBrk, KeyA, CodeRShiftBrk,
    CodeCapsLock, CodeEnter, CodeNumLock, CodeScrollLock, CodeCapsLock | BreakBit,
    ByteAck, ByteResend, KeyPadDot, RomLimit, KeySpace, BreakBit
  };

  typedef struct packed {
    char_t key_code;
    logic  key_valid;
    logic  led_changed;
    leds_t led_state;
  } key_result_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_we;
  leds_t cfg_data;

  kbdsc_code_if scan_if ();
  kbdsc_key_if  key_if ();

  keyboard_scancode_to_ascii u_dut (
    .clk      (clk),
    .rst      (rst),
    .scan     (scan_if),
    .key      (key_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted keyboard state and pending traffic.
  shift_t      shift_keys;
  leds_t       lock_bits;
  code_t       pending_codes [$];
  key_result_t expected_keys [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_stall_req = 1'b0;
  int stall_left;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Decode one scan code against the predicted state and advance that state.
  // Lock keys toggle first; the table lookup sees the shift state from before
  // this code; shift make/break updates come last.
  function automatic key_result_t decode_scan(input code_t code);
    key_result_t res;
    char_t       ch;
    ch = ChNone;
    res.led_changed = 1'b0;
    case (code)
      CodeCapsLock: begin
        lock_bits = lock_bits ^ LedCaps;
        res.led_changed = 1'b1;
      end
      CodeNumLock: begin
        lock_bits = lock_bits ^ LedNum;
        res.led_changed = 1'b1;
      end
      CodeScrollLock: begin
        lock_bits = lock_bits ^ LedScroll;
        res.led_changed = 1'b1;
      end
      default: ;
    endcase
    if (code < RomLimit) begin
      if (shift_keys == ShiftNone) begin
        ch = PlainKeys[code[6:0]];
      end else if (shift_keys != ShiftBoth) begin
        ch = ShiftedKeys[code[6:0]];
      end
      // Letters stay upper case only when exactly one of caps and shift applies.
      if (ch >= ChUpperA && ch <= ChUpperZ &&
          ((lock_bits & LedCaps) != LedsOff) == (shift_keys != ShiftNone)) begin
        ch = ch + CaseOffset;
      end
    end
    if (code == CodeBackspace) ch = ChBackspace;
    if (code == CodeEnter) ch = ChEnter;
    case (code)
      CodeLShiftMake: shift_keys = shift_keys | 2'b01;
      CodeRShiftMake: shift_keys = shift_keys | 2'b10;
      CodeLShiftBrk:  shift_keys = shift_keys & 2'b10;
      CodeRShiftBrk:  shift_keys = shift_keys & 2'b01;
      default: ;
    endcase
    res.key_code  = ch;
    res.key_valid = (ch != ChNone);
    res.led_state = lock_bits;
    return res;
  endfunction

  // Driver: offer the next pending code whenever the channel is free, and
  // update the prediction on every accepted item and every register write.
  always @(posedge clk) begin
    if (rst) begin
      scan_if.valid     <= 1'b0;
      scan_if.scan_code <= ByteZero;
      shift_keys = ShiftNone;
      lock_bits  = LedsOff;
      expected_keys.delete();
    end else begin
      if (cfg_we) lock_bits = cfg_data;
      if (scan_if.valid && scan_if.ready) begin
        expected_keys.push_back(decode_scan(scan_if.scan_code));
      end
      if (!scan_if.valid || scan_if.ready) begin
        if (pending_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          scan_if.valid     <= 1'b1;
          scan_if.scan_code <= pending_codes.pop_front();
        end else begin
          scan_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_field(input string field, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  // Monitor: check each accepted result against the oldest prediction, and
  // drive ready with random stalls or a long hold when one is requested.
  always @(posedge clk) begin
    key_result_t want;
    if (rst) begin
      key_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (key_if.valid && key_if.ready) begin
        if (expected_keys.size() == 0) begin
          report_field("unexpected item key_code", 0, key_if.key_code);
        end else begin
          want = expected_keys.pop_front();
          if (key_if.key_code !== want.key_code)
            report_field("key_code", want.key_code, key_if.key_code);
          if (key_if.key_valid !== want.key_valid)
            report_field("key_valid", want.key_valid, key_if.key_valid);
          if (key_if.led_changed !== want.led_changed)
            report_field("led_changed", want.led_changed, key_if.led_changed);
          if (key_if.led_state !== want.led_state)
            report_field("led_state", want.led_state, key_if.led_state);
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        key_if.ready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left   <= LongStall;
        key_if.ready <= 1'b0;
      end else begin
        key_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((scan_if.valid && scan_if.ready) || (key_if.valid && key_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold until every queued code is accepted and every result is back.
  // Sample on the falling edge so the driver and monitor have settled.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_codes.size() != 0 || scan_if.valid || expected_keys.size() != 0)
      @(negedge clk);
  endtask

  task automatic load_leds(input leds_t value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic push_code(input code_t code, inout int added);
    pending_codes.push_back(code);
    added++;
  endtask

  // Queue typing traffic: mostly key presses with releases and shifted bursts,
  // some lock toggles, and the rest raw noise bytes.
  task automatic queue_typing(input int count);
    int    added;
    int    pick;
    int    which;
    int    burst;
    code_t key;
    code_t lock_key;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        key = code_t'($urandom_range(RomLimit - 1));
        push_code(key, added);
        if ($urandom_range(3) != 0) push_code(key | BreakBit, added);
      end else if (pick < 75) begin
        // Shifted burst: left, right or both shifts around a few keys.
        which = $urandom_range(2);
        if (which != 1) push_code(CodeLShiftMake, added);
        if (which != 0) push_code(CodeRShiftMake, added);
        burst = $urandom_range(4, 1);
        repeat (burst) push_code(code_t'($urandom_range(RomLimit - 1)), added);
        if (which != 1) push_code(CodeLShiftBrk, added);
        if (which != 0) push_code(CodeRShiftBrk, added);
      end else if (pick < 87) begin
        case ($urandom_range(2))
          0: lock_key = CodeCapsLock;
          1: lock_key = CodeNumLock;
          default: lock_key = CodeScrollLock;
        endcase
        push_code(lock_key, added);
        if ($urandom_range(1) != 0) push_code(lock_key | BreakBit, added);
      end else begin
        push_code(code_t'($urandom_range(255)), added);
      end
    end
  endtask

  initial begin
    leds_t phase_leds [PhaseCount];
    int    phase_send [PhaseCount];
    int    phase_recv [PhaseCount];
    // Phases: no idling, sender idle, receiver stalling, both idling.
    phase_leds = '{LedsAll, LedsOff, 3'b101, 3'b010};
    phase_send = '{0, 56, 0, 16};
    phase_recv = '{0, 0, 56, 16};

    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = LedsOff;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed pass from a known LED state.
    load_leds(LedsOff);
    foreach (DirectedCodes[i]) pending_codes.push_back(DirectedCodes[i]);
    wait_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      // Write the LED register only once the pipe has drained.
      load_leds(phase_leds[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (phase_recv[p] != 0 && phase_send[p] == 0) begin
        // Hold the receiver for a long stretch while codes keep coming,
        // so the block fills up and drops scan ready.
        long_stall_req = 1'b1;
      end
      if (phase_send[p] != 0 && phase_recv[p] == 0) begin
        // Pause the sender halfway until every result has come back.
        queue_typing(PhaseItems / 2);
        wait_idle();
        queue_typing(PhaseItems - PhaseItems / 2);
      end else begin
        queue_typing(PhaseItems);
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+design
design/kbdsc_pkg.sv
design/kbdsc_code_if.sv
design/kbdsc_key_if.sv
design/kbdsc_decode.sv
design/keyboard_scancode_to_ascii.sv
design/kbdsc_checker.sv
bench/testbench.sv
